// ===== src/column_scale_by_std_core_macros.svh =====
// Assertion macros shared by the column scaling RTL.
`ifndef COLUMN_SCALE_BY_STD_CORE_MACROS_SVH
`define COLUMN_SCALE_BY_STD_CORE_MACROS_SVH

// Property checked at every rising edge outside reset.
`define CSBS_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("csbs check failed");

// Condition in one cycle implies a consequence in the next.
`define CSBS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("csbs sequence check failed");

`endif

// ===== src/csbs_pkg.sv =====
// Shared types and constants for the column scaling block.
package csbs_pkg;

	localparam int DEF_MAX_ROWS = 64;
	localparam int QDEPTH       = 4;

	// Shared divider sizes
	localparam int DIV_W      = 72;
	localparam int DVS_W      = 37;
	localparam int STEP_W     = 7;
	localparam int MEAN_STEPS = 40;
	localparam int VAR_STEPS  = 72;
	localparam int SCL_STEPS  = 48;

	// Square root: two radicand bits per step
	localparam int SQRT_STEPS = 36;

	// Result status codes
	localparam logic [1:0] ST_SCALED = 2'd0;
	localparam logic [1:0] ST_ZERO   = 2'd1;
	localparam logic [1:0] ST_ONE    = 2'd2;
	localparam logic [1:0] ST_TRUNC  = 2'd3;

	typedef struct packed {
		logic [31:0] sample;
		logic        last;
	} item_t;

	typedef struct packed {
		logic              start;
		logic [DIV_W-1:0]  dividend;
		logic [DVS_W-1:0]  divisor;
		logic [STEP_W-1:0] steps;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [DIV_W-1:0] quotient;
		logic             rem_nz;
	} div_rsp_t;

endpackage

// ===== src/csbs_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
module csbs_div (
	input  logic                clk,
	input  logic                arst_n,
	input  csbs_pkg::div_req_t  req,
	output csbs_pkg::div_rsp_t  rsp
);

	logic [csbs_pkg::DIV_W-1:0]  quo_q;
	logic [csbs_pkg::DVS_W-1:0]  rem_q;
	logic [csbs_pkg::DVS_W-1:0]  dvs_q;
	logic [csbs_pkg::STEP_W-1:0] cnt_q;
	logic                        busy_q;
	logic                        done_q;
	logic [csbs_pkg::DVS_W:0]    trial;
	logic                        fits;

	// Shift in next dividend bit and try a subtraction
	assign trial = {rem_q, quo_q[csbs_pkg::DIV_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			// One-cycle done pulse after the final step
			done_q <= !req.start && busy_q && (cnt_q == csbs_pkg::STEP_W'(1));
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == csbs_pkg::STEP_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[csbs_pkg::DIV_W-2:0], fits};
			rem_q <= fits ? csbs_pkg::DVS_W'(trial - {1'b0, dvs_q})
			              : trial[csbs_pkg::DVS_W-1:0];
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;
	assign rsp.rem_nz   = |rem_q;

endmodule

// ===== src/csbs_front.sv =====
// Input side: accepts sample beats into a short queue for the back end.
module csbs_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [31:0]         s_axis_tdata,   // sample
	input  logic                s_axis_tlast,
	output csbs_pkg::item_t     q_item,
	output logic                q_valid,
	input  logic                q_ready
);

	localparam int PW = $clog2(csbs_pkg::QDEPTH);

	csbs_pkg::item_t fifo_q [csbs_pkg::QDEPTH];
	logic [PW-1:0]   wp_q;
	logic [PW-1:0]   rp_q;
	logic [PW:0]     fill_q;
	logic            push;
	logic            pop;

	assign s_axis_tready = fill_q != (PW+1)'(csbs_pkg::QDEPTH);
	assign q_valid       = fill_q != '0;
	assign push          = s_axis_tvalid && s_axis_tready;
	assign pop           = q_valid && q_ready;
	assign q_item        = fifo_q[rp_q];

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			rp_q   <= '0;
			fill_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			if (push && !pop) fill_q <= fill_q + 1'b1;
			else if (pop && !push) fill_q <= fill_q - 1'b1;
		end
	end

	// Queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wp_q].sample <= s_axis_tdata;
			fifo_q[wp_q].last   <= s_axis_tlast;
		end
	end

endmodule

// ===== src/csbs_back.sv =====
// Back end: column store, statistics, square root and scaling sequencer.
`include "column_scale_by_std_core_macros.svh"
module csbs_back #(
	parameter int MAX_ROWS = csbs_pkg::DEF_MAX_ROWS
) (
	input  logic            clk,
	input  logic            arst_n,
	input  csbs_pkg::item_t q_item,
	input  logic            q_valid,
	output logic            q_ready,
	output logic            m_axis_tvalid,
	input  logic            m_axis_tready,
	output logic [31:0]     m_axis_tdata,   // scaled_value
	output logic            m_axis_tlast,
	output logic [1:0]      m_axis_tuser    // status
);

	localparam int CW    = $clog2(MAX_ROWS + 1);
	localparam int AW    = $clog2(MAX_ROWS);
	localparam int SW    = 32 + CW;
	localparam int ACC_W = 64 + CW;

	typedef enum logic [13:0] {
		S_LOAD  = 14'b00000000000001,
		S_MEAN  = 14'b00000000000010,
		S_MEANW = 14'b00000000000100,
		S_VRD   = 14'b00000000001000,
		S_VSUB  = 14'b00000000010000,
		S_VMUL  = 14'b00000000100000,
		S_VACC  = 14'b00000001000000,
		S_VDIV  = 14'b00000010000000,
		S_VDIVW = 14'b00000100000000,
		S_SQRT  = 14'b00001000000000,
		S_ERD   = 14'b00010000000000,
		S_EDAT  = 14'b00100000000000,
		S_EDIVW = 14'b01000000000000,
		S_EOUT  = 14'b10000000000000
	} state_t;

	state_t                state_q;
	logic [31:0]           mem [MAX_ROWS];
	logic [31:0]           rd_q;
	logic [CW-1:0]         cnt_q;
	logic [CW-1:0]         idx_q;
	logic signed [SW-1:0]  sum_q;
	logic                  ovf_q;
	logic                  neg_q;
	logic signed [32:0]    mean_q;
	logic [31:0]           dev_q;
	logic [63:0]           sq_q;
	logic [ACC_W-1:0]      acc_q;
	logic [csbs_pkg::DIV_W-1:0] rad_q;
	logic [35:0]           root_q;
	logic [37:0]           srem_q;
	logic [5:0]            sqi_q;
	logic [31:0]           res_q;
	logic                  out_valid_q;
	logic [31:0]           out_data_q;
	logic                  out_last_q;
	logic [1:0]            out_status_q;

	csbs_pkg::div_req_t    div_req;
	csbs_pkg::div_rsp_t    div_rsp;

	logic                  full;
	logic [CW-1:0]         cnt_nxt;
	logic [SW-1:0]         sum_mag;
	logic signed [33:0]    diff;
	logic [39:0]           sq_t;
	logic [37:0]           sq_trial;
	logic                  sq_fit;
	logic                  rd_neg;
	logic [31:0]           rd_mag;
	logic [32:0]           mean_mag;
	logic [47:0]           q48;
	logic [31:0]           sat;
	logic                  scale_en;
	logic [1:0]            status;
	logic                  out_free;
	logic                  last_idx;

	csbs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Load side
	assign full     = cnt_q == CW'(MAX_ROWS);
	assign cnt_nxt  = full ? cnt_q : cnt_q + 1'b1;
	assign q_ready  = state_q == S_LOAD;
	assign sum_mag  = sum_q[SW-1] ? SW'(-sum_q) : SW'(sum_q);

	// Variance helpers
	assign diff     = 34'($signed(rd_q)) - 34'(mean_q);
	assign mean_mag = div_rsp.quotient[32:0] + 33'(neg_q & div_rsp.rem_nz);

	// Square root step
	assign sq_t     = {srem_q, rad_q[csbs_pkg::DIV_W-1 -: 2]};
	assign sq_trial = {root_q, 2'b01};
	assign sq_fit   = sq_t >= {2'b00, sq_trial};

	// Scaling helpers
	assign rd_neg   = rd_q[31];
	assign rd_mag   = rd_neg ? 32'(-rd_q) : rd_q;
	assign q48      = div_rsp.quotient[47:0];
	always_comb begin
		if (rd_neg) begin
			sat = (q48 > 48'h0000_8000_0000) ? 32'h8000_0000 : 32'(-q48[31:0]);
		end else begin
			sat = (q48 > 48'h0000_7FFF_FFFF) ? 32'h7FFF_FFFF : q48[31:0];
		end
	end

	// Result status of the column being emitted
	assign scale_en = (cnt_q >= CW'(2)) && (root_q != '0);
	always_comb begin
		if (ovf_q) status = csbs_pkg::ST_TRUNC;
		else if (cnt_q < CW'(2)) status = csbs_pkg::ST_ONE;
		else if (root_q == '0) status = csbs_pkg::ST_ZERO;
		else status = csbs_pkg::ST_SCALED;
	end

	assign out_free = !out_valid_q || m_axis_tready;
	assign last_idx = (idx_q + 1'b1) == cnt_q;

	// Divider requests
	always_comb begin
		div_req = '0;
		case (state_q)
			S_MEAN: begin
				div_req.start    = 1'b1;
				div_req.dividend = csbs_pkg::DIV_W'(sum_mag)
				                   << (csbs_pkg::DIV_W - csbs_pkg::MEAN_STEPS);
				div_req.divisor  = csbs_pkg::DVS_W'(cnt_q);
				div_req.steps    = csbs_pkg::STEP_W'(csbs_pkg::MEAN_STEPS);
			end
			S_VDIV: begin
				div_req.start    = 1'b1;
				div_req.dividend = csbs_pkg::DIV_W'(acc_q);
				div_req.divisor  = csbs_pkg::DVS_W'(cnt_q - 1'b1);
				div_req.steps    = csbs_pkg::STEP_W'(csbs_pkg::VAR_STEPS);
			end
			S_EDAT: begin
				div_req.start    = scale_en;
				div_req.dividend = csbs_pkg::DIV_W'({rd_mag, 16'h0000})
				                   << (csbs_pkg::DIV_W - csbs_pkg::SCL_STEPS);
				div_req.divisor  = csbs_pkg::DVS_W'(root_q);
				div_req.steps    = csbs_pkg::STEP_W'(csbs_pkg::SCL_STEPS);
			end
			default: ;
		endcase
	end

	// Column store: write on load, registered read
	always_ff @(posedge clk) begin
		if (state_q == S_LOAD && q_valid && !full) mem[cnt_q[AW-1:0]] <= q_item.sample;
		rd_q <= mem[idx_q[AW-1:0]];
	end

	// Sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_LOAD;
			cnt_q       <= '0;
			sum_q       <= '0;
			ovf_q       <= 1'b0;
			idx_q       <= '0;
			root_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// Output beat taken; the emit state reloads it itself
			if (m_axis_tready && state_q != S_EOUT) out_valid_q <= 1'b0;
			case (state_q)
				S_LOAD: begin
					if (q_valid) begin
						cnt_q <= cnt_nxt;
						if (full) ovf_q <= 1'b1;
						else sum_q <= sum_q + SW'($signed(q_item.sample));
						idx_q <= '0;
						if (q_item.last) begin
							root_q  <= '0;
							state_q <= (cnt_nxt < CW'(2)) ? S_ERD : S_MEAN;
						end
					end
				end
				S_MEAN:  state_q <= S_MEANW;
				S_MEANW: if (div_rsp.done) state_q <= S_VRD;
				S_VRD:   state_q <= S_VSUB;
				S_VSUB:  state_q <= S_VMUL;
				S_VMUL:  state_q <= S_VACC;
				S_VACC: begin
					idx_q   <= idx_q + 1'b1;
					state_q <= last_idx ? S_VDIV : S_VRD;
				end
				S_VDIV:  state_q <= S_VDIVW;
				S_VDIVW: if (div_rsp.done) state_q <= S_SQRT;
				S_SQRT: begin
					root_q <= {root_q[34:0], sq_fit};
					if (sqi_q == 6'(csbs_pkg::SQRT_STEPS - 1)) begin
						idx_q   <= '0;
						state_q <= S_ERD;
					end
				end
				S_ERD:   state_q <= S_EDAT;
				S_EDAT:  state_q <= scale_en ? S_EDIVW : S_EOUT;
				S_EDIVW: if (div_rsp.done) state_q <= S_EOUT;
				S_EOUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						idx_q       <= idx_q + 1'b1;
						if (last_idx) begin
							cnt_q   <= '0;
							sum_q   <= '0;
							ovf_q   <= 1'b0;
							state_q <= S_LOAD;
						end else begin
							state_q <= S_ERD;
						end
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	// Arithmetic registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_MEAN: neg_q <= sum_q[SW-1];
			S_MEANW: begin
				if (div_rsp.done) begin
					mean_q <= neg_q ? -$signed(mean_mag) : $signed(mean_mag);
					acc_q  <= '0;
				end
			end
			S_VSUB: dev_q <= diff[33] ? 32'(-diff) : 32'(diff);
			S_VMUL: sq_q  <= dev_q * dev_q;
			S_VACC: acc_q <= acc_q + ACC_W'(sq_q);
			S_VDIVW: begin
				if (div_rsp.done) begin
					rad_q  <= div_rsp.quotient;
					srem_q <= '0;
					sqi_q  <= '0;
				end
			end
			S_SQRT: begin
				srem_q <= sq_fit ? 38'(sq_t - {2'b00, sq_trial}) : sq_t[37:0];
				rad_q  <= rad_q << 2;
				sqi_q  <= sqi_q + 1'b1;
			end
			S_EDAT:  res_q <= rd_q;
			S_EDIVW: if (div_rsp.done) res_q <= sat;
			S_EOUT: begin
				if (out_free) begin
					out_data_q   <= res_q;
					out_last_q   <= last_idx;
					out_status_q <= status;
				end
			end
			default: ;
		endcase
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tuser  = out_status_q;

	// Checks
	`CSBS_ASSERT(a_cnt_bound, cnt_q <= CW'(MAX_ROWS))
	`CSBS_ASSERT(a_load_div_idle, (state_q == S_LOAD) |-> !div_rsp.busy)
	`CSBS_ASSERT(a_one_row_last, (out_valid_q && out_status_q == csbs_pkg::ST_ONE) |-> out_last_q)
	`CSBS_ASSERT_NEXT(a_done_pulse, div_rsp.done, !div_rsp.done)

endmodule

// ===== src/column_scale_by_std_core.sv =====
// Flow: sample beats are queued; the column is held until its last beat.
// After the last beat the block computes the mean, makes a variance pass over the samples,
// divides the sum of squares by n-1, takes the square root, then divides each value by the
// root in the shared divider; values that pass unchanged skip it. One column in work at a time.
// Reset (arst_n low, asynchronous) empties the queue, the counts and the output register.
// The column store needs no clearing pass.
module column_scale_by_std_core #(
	parameter int MAX_ROWS = csbs_pkg::DEF_MAX_ROWS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // sample
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // scaled_value
	output logic        m_axis_tlast,
	output logic [1:0]  m_axis_tuser    // status
);

	csbs_pkg::item_t q_item;
	logic            q_valid;
	logic            q_ready;

	csbs_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.q_item        (q_item),
		.q_valid       (q_valid),
		.q_ready       (q_ready)
	);

	csbs_back #(
		.MAX_ROWS (MAX_ROWS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_item        (q_item),
		.q_valid       (q_valid),
		.q_ready       (q_ready),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule
